// ===== sv/mvpm_pkg.sv =====
package mvpm_pkg;

    localparam int POS_W  = 17;
    localparam int PROD_W = 26;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_WRITE      = 3'd1;
    localparam logic [2:0] OP_START_ONCE = 3'd2;
    localparam logic [2:0] OP_START_LOOP = 3'd3;
    localparam logic [2:0] OP_STOP       = 3'd4;
    localparam logic [2:0] OP_SET_VOLUME = 3'd5;

    localparam logic [POS_W-1:0] MAX_LENGTH = 17'h10000;
    localparam logic [15:0]      UNITY_GAIN = 16'd256;
    localparam logic [7:0]       MID_LEVEL  = 8'd128;
    localparam logic [7:0]       MAX_LEVEL  = 8'd255;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [7:0]  sample_byte;
        logic [16:0] length;
        logic [16:0] loop_offset;
        logic [2:0]  voice;
        logic [15:0] voice_gain;
        logic [7:0]  stream_sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] mixed_sample;
        logic [2:0] voice_taken;
        logic       no_free_voice;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic exec_op;
        logic scan_step;
        logic issue_write;
        logic load_result;
    } mvpm_cmd_t;

    typedef struct packed {
        logic scan_last;
    } mvpm_status_t;

endpackage

// ===== sv/mvpm_ctrl.sv =====
module mvpm_ctrl
    import mvpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [2:0]   op,
    input  logic         out_ready,
    input  mvpm_status_t status,
    output logic         in_ready,
    output logic         out_valid,
    output mvpm_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    localparam logic [2:0] DRAIN_LAST = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] drain_cnt_reg;
    logic       out_valid_reg;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.capture     = accept;
        cmd.exec_op     = (state_reg == ST_EXEC);
        cmd.scan_step   = (state_reg == ST_SCAN);
        cmd.issue_write = (state_reg == ST_WRITE);
        cmd.load_result = (state_reg == ST_RESULT) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (op == OP_TICK)
                        state_next = ST_SCAN;
                    else if (op == OP_WRITE)
                        state_next = ST_WRITE;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_EXEC:
                state_next = ST_RESULT;
            ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_WRITE:
                state_next = ST_DRAIN;
            ST_DRAIN:
            begin
                if (drain_cnt_reg == DRAIN_LAST)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drain_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DRAIN)
                drain_cnt_reg <= drain_cnt_reg + 3'd1;
            else
                drain_cnt_reg <= '0;
            if (cmd.load_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== sv/mvpm_datapath.sv =====
module mvpm_datapath
    import mvpm_pkg::*;
#(
    parameter int VOICES       = 8,
    parameter int SAMPLE_DEPTH = 65536
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  mvpm_cmd_t    cmd,
    input  in_item_t     in_data,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data,
    output mvpm_status_t status,
    output out_item_t    out_data
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MEM_AW = $clog2(SAMPLE_DEPTH);
    localparam int SUM_W  = PROD_W + $clog2(VOICES + 1);
    localparam logic [26:0] RECIP   = 27'((64'd1 << 34) / SAMPLE_DEPTH);
    localparam logic [24:0] DEPTH_C = 25'(SAMPLE_DEPTH);

    in_item_t    item_reg;
    logic [15:0] stream_vol_reg;

    logic [POS_W-1:0] pos_reg  [VOICES];
    logic [POS_W-1:0] loop_reg [VOICES];
    logic [POS_W-1:0] end_reg  [VOICES];
    logic [15:0]      vol_reg  [VOICES];
    logic [VOICES-1:0] active_reg;
    logic [VIDX_W-1:0] scan_idx_reg;

    logic [7:0] mem [SAMPLE_DEPTH];

    logic              p1_valid_reg;
    logic              p1_wr_reg;
    logic [POS_W-1:0]  p1_pos_reg;
    logic [15:0]       p1_vol_reg;
    logic [7:0]        p1_data_reg;
    logic              p2_valid_reg;
    logic              p2_wr_reg;
    logic [POS_W-1:0]  p2_pos_reg;
    logic [9:0]        p2_q_reg;
    logic [15:0]       p2_vol_reg;
    logic [7:0]        p2_data_reg;
    logic              p3_valid_reg;
    logic              p3_wr_reg;
    logic [MEM_AW-1:0] p3_idx_reg;
    logic [15:0]       p3_vol_reg;
    logic [7:0]        p3_data_reg;
    logic              p4_valid_reg;
    logic [15:0]       p4_vol_reg;
    logic [7:0]        rdata_reg;
    logic              p5_valid_reg;
    logic signed [PROD_W-1:0] p5_prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;

    logic       taken_reg;
    logic [2:0] taken_idx_reg;
    logic       nofree_reg;
    out_item_t  out_reg;

    logic [POS_W-1:0] cur_pos;
    logic [POS_W-1:0] cur_loop;
    logic [POS_W-1:0] cur_end;
    logic [15:0]      cur_vol;
    logic             issue;
    logic [POS_W:0]   step_sum;
    logic             at_end;

    logic [43:0] q_prod;
    logic [34:0] qd;
    logic [35:0] rem;
    logic [35:0] rem_fix;

    logic signed [7:0]        smp;
    logic signed [7:0]        stream_smp;
    logic signed [PROD_W-1:0] stream_prod;

    logic              free_found;
    logic [VIDX_W-1:0] free_idx;
    logic              is_start;
    logic [POS_W-1:0]  len_c;
    logic [POS_W-1:0]  start_end;
    logic [POS_W-1:0]  start_loop;

    logic signed [SUM_W-1:0] level;
    logic [7:0]              level_c;
    out_item_t               result_next;

    // voice scan
    assign cur_pos  = pos_reg[scan_idx_reg];
    assign cur_loop = loop_reg[scan_idx_reg];
    assign cur_end  = end_reg[scan_idx_reg];
    assign cur_vol  = vol_reg[scan_idx_reg];
    assign issue    = cmd.scan_step && active_reg[scan_idx_reg];
    assign step_sum = {1'b0, cur_pos} + 18'd1;
    assign at_end   = step_sum >= {1'b0, cur_end};

    assign status.scan_last = (scan_idx_reg == VIDX_W'(VOICES - 1));

    // address modulo memory depth
    assign q_prod  = 44'(p1_pos_reg) * 44'(RECIP);
    assign qd      = 35'(p2_q_reg) * 35'(DEPTH_C);
    assign rem     = 36'(p2_pos_reg) - 36'(qd);
    assign rem_fix = (rem >= 36'(DEPTH_C)) ? rem - 36'(DEPTH_C) : rem;

    assign smp         = {~rdata_reg[7], rdata_reg[6:0]};
    assign stream_smp  = {~in_data.stream_sample[7], in_data.stream_sample[6:0]};
    assign stream_prod = PROD_W'(stream_smp) * PROD_W'($signed({1'b0, stream_vol_reg}));

    // lowest free voice
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = VOICES - 1; v >= 0; v--)
        begin
            if (!active_reg[v])
            begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(v);
            end
        end
    end

    assign is_start  = cmd.exec_op && ((item_reg.operation == OP_START_ONCE) ||
                                       (item_reg.operation == OP_START_LOOP));
    assign len_c     = (item_reg.length > MAX_LENGTH) ? MAX_LENGTH : item_reg.length;
    assign start_end = {1'b0, item_reg.address} + len_c;
    assign start_loop = ((item_reg.operation == OP_START_LOOP) &&
                         (item_reg.loop_offset < len_c)) ?
                        {1'b0, item_reg.address} + item_reg.loop_offset : start_end;

    // output level
    assign level = (acc_reg >>> 8) + $signed(SUM_W'(MID_LEVEL));

    always_comb
    begin
        priority if (level < 0)
            level_c = 8'd0;
        else if (level > $signed(SUM_W'(MAX_LEVEL)))
            level_c = MAX_LEVEL;
        else
            level_c = level[7:0];
    end

    always_comb
    begin
        result_next.mixed_sample  = (item_reg.operation == OP_TICK) ? level_c : MID_LEVEL;
        result_next.voice_taken   = taken_reg ? taken_idx_reg : 3'd0;
        result_next.no_free_voice = nofree_reg;
    end

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_vol_reg <= '0;
            active_reg     <= '0;
            scan_idx_reg   <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            p4_valid_reg   <= 1'b0;
            p5_valid_reg   <= 1'b0;
            taken_reg      <= 1'b0;
            nofree_reg     <= 1'b0;
            for (int v = 0; v < VOICES; v++)
            begin
                pos_reg[v]  <= '0;
                loop_reg[v] <= '0;
                end_reg[v]  <= '0;
                vol_reg[v]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                stream_vol_reg <= cfg_data;

            if (cmd.capture)
                scan_idx_reg <= '0;
            else if (cmd.scan_step && !status.scan_last)
                scan_idx_reg <= scan_idx_reg + VIDX_W'(1);

            for (int v = 0; v < VOICES; v++)
            begin
                if (issue && (scan_idx_reg == VIDX_W'(v)))
                begin
                    if (at_end && (cur_loop < cur_end))
                        pos_reg[v] <= cur_loop;
                    else
                        pos_reg[v] <= step_sum[POS_W-1:0];
                    if (at_end && !(cur_loop < cur_end))
                        active_reg[v] <= 1'b0;
                end
                else if (is_start && free_found && (free_idx == VIDX_W'(v)))
                begin
                    pos_reg[v]    <= {1'b0, item_reg.address};
                    end_reg[v]    <= start_end;
                    loop_reg[v]   <= start_loop;
                    vol_reg[v]    <= UNITY_GAIN;
                    active_reg[v] <= 1'b1;
                end
                else if (cmd.exec_op && (item_reg.operation == OP_STOP) &&
                         (int'(item_reg.voice) == v))
                begin
                    active_reg[v] <= 1'b0;
                end
                else if (cmd.exec_op && (item_reg.operation == OP_SET_VOLUME) &&
                         (int'(item_reg.voice) == v))
                begin
                    vol_reg[v] <= item_reg.voice_gain;
                end
            end

            p1_valid_reg <= issue || cmd.issue_write;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg && !p3_wr_reg;
            p5_valid_reg <= p4_valid_reg;

            if (cmd.capture)
            begin
                taken_reg  <= 1'b0;
                nofree_reg <= 1'b0;
            end
            else if (is_start)
            begin
                taken_reg  <= free_found;
                nofree_reg <= !free_found;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (is_start)
            taken_idx_reg <= 3'(free_idx);

        if (issue)
        begin
            p1_wr_reg  <= 1'b0;
            p1_pos_reg <= cur_pos;
            p1_vol_reg <= cur_vol;
        end
        else if (cmd.issue_write)
        begin
            p1_wr_reg   <= 1'b1;
            p1_pos_reg  <= {1'b0, item_reg.address};
            p1_data_reg <= item_reg.sample_byte;
        end

        p2_wr_reg   <= p1_wr_reg;
        p2_pos_reg  <= p1_pos_reg;
        p2_q_reg    <= q_prod[43:34];
        p2_vol_reg  <= p1_vol_reg;
        p2_data_reg <= p1_data_reg;

        p3_wr_reg   <= p2_wr_reg;
        p3_idx_reg  <= rem_fix[MEM_AW-1:0];
        p3_vol_reg  <= p2_vol_reg;
        p3_data_reg <= p2_data_reg;

        p4_vol_reg  <= p3_vol_reg;
        p5_prod_reg <= PROD_W'(smp) * PROD_W'($signed({1'b0, p4_vol_reg}));

        if (cmd.capture)
            acc_reg <= SUM_W'(stream_prod);
        else if (p5_valid_reg)
            acc_reg <= acc_reg + SUM_W'(p5_prod_reg);

        if (cmd.load_result)
            out_reg <= result_next;
    end

    // sample memory, one port
    always_ff @(posedge clk)
    begin
        if (p3_valid_reg)
        begin
            if (p3_wr_reg)
                mem[p3_idx_reg] <= p3_data_reg;
            else
                rdata_reg <= mem[p3_idx_reg];
        end
    end

endmodule

// ===== sv/multi_voice_pcm_mixer.sv =====
// tick: after the input transfer the voices are scanned one voice per cycle
// through the shared address-reduce, memory-read and multiply pipeline, which then drains
// write sample: through the pipeline to the memory port; start, stop, set volume: EXEC state
// one operation in flight; the next transfer is taken the cycle after the result is registered,
// so no new item is taken before the last result is registered, which waits for a free out slot
// async reset clears control, voice state and stream volume; sample memory is not cleared
module multi_voice_pcm_mixer
    import mvpm_pkg::*;
#(
    parameter int VOICES       = 8,
    parameter int SAMPLE_DEPTH = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    mvpm_cmd_t    cmd;
    mvpm_status_t status;

    assign cfg_ready = 1'b1;

    mvpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (in_data.operation),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mvpm_datapath #(
        .VOICES       (VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .status   (status),
        .out_data (out_data)
    );

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an operation is in flight");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised without an operation in progress");

    a_start_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.no_free_voice && (out_data.voice_taken != 3'd0)))
        else $error("voice reported taken and none free together");
`endif

endmodule

// ===== bench/multi_voice_pcm_mixer_tb.sv =====
module multi_voice_pcm_mixer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mvpm_pkg::*;

    localparam int NUM_VOICES    = 8;
    localparam int MEM_SPAN      = 65536;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {READY_ALWAYS, READY_LIGHT, READY_HEAVY} ready_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // mixer state as the block should hold it
    logic [7:0]  sample_mem [MEM_SPAN];
    bit          sample_known [MEM_SPAN];
    int unsigned voice_pos [NUM_VOICES];
    int unsigned voice_loop [NUM_VOICES];
    int unsigned voice_stop_at [NUM_VOICES];
    logic [15:0] voice_gain [NUM_VOICES] = '{default: '0};
    bit          voice_on [NUM_VOICES];
    logic [15:0] stream_gain = '0;
    out_item_t   pending_results [$];

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on = 1'b0;
    int          burst_left = 1;
    ready_mode_t ready_mode = READY_LIGHT;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age = 0;

    multi_voice_pcm_mixer #(
        .VOICES       (NUM_VOICES),
        .SAMPLE_DEPTH (MEM_SPAN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic out_item_t mixer_predict(in_item_t it);
        out_item_t   res;
        longint      acc;
        int          level;
        int          gain;
        int          v;
        int          slot;
        int unsigned span;
        res.mixed_sample  = MID_LEVEL;
        res.voice_taken   = '0;
        res.no_free_voice = 1'b0;
        slot = -1;
        case (it.operation)
            OP_TICK:
            begin
                acc = 0;
                for (v = 0; v < NUM_VOICES; v++)
                begin
                    if (voice_on[v])
                    begin
                        level = int'(sample_mem[voice_pos[v] % MEM_SPAN]) - int'(MID_LEVEL);
                        gain = int'(voice_gain[v]);
                        acc += longint'(level) * longint'(gain);
                        voice_pos[v]++;
                        if (voice_pos[v] >= voice_stop_at[v])
                        begin
                            if (voice_loop[v] < voice_stop_at[v])
                                voice_pos[v] = voice_loop[v];
                            else
                                voice_on[v] = 1'b0;
                        end
                    end
                end
                level = int'(it.stream_sample) - int'(MID_LEVEL);
                gain = int'(stream_gain);
                acc += longint'(level) * longint'(gain);
                acc = (acc >>> 8) + int'(MID_LEVEL);
                if (acc > int'(MAX_LEVEL))
                    res.mixed_sample = MAX_LEVEL;
                else if (acc < 0)
                    res.mixed_sample = '0;
                else
                    res.mixed_sample = acc[7:0];
            end
            OP_WRITE:
            begin
                sample_mem[it.address]   = it.sample_byte;
                sample_known[it.address] = 1'b1;
            end
            OP_START_ONCE, OP_START_LOOP:
            begin
                for (v = 0; v < NUM_VOICES; v++)
                begin
                    if (slot < 0 && !voice_on[v])
                        slot = v;
                end
                if (slot < 0)
                    res.no_free_voice = 1'b1;
                else
                begin
                    span = 32'((it.length > MAX_LENGTH) ? MAX_LENGTH : it.length);
                    voice_pos[slot]     = 32'(it.address);
                    voice_stop_at[slot] = 32'(it.address) + span;
                    if (it.operation == OP_START_LOOP && it.loop_offset < span)
                        voice_loop[slot] = 32'(it.address) + 32'(it.loop_offset);
                    else
                        voice_loop[slot] = 32'(it.address) + span;
                    voice_gain[slot]  = UNITY_GAIN;
                    voice_on[slot]    = 1'b1;
                    res.voice_taken   = slot[2:0];
                end
            end
            OP_STOP:
                voice_on[it.voice] = 1'b0;
            OP_SET_VOLUME:
                voice_gain[it.voice] = it.voice_gain;
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // a result transfer happens at the edge after this sample
    always @(negedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transfer", out_data.mixed_sample, -1);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.mixed_sample !== want.mixed_sample)
                    report_mismatch("mixed_sample", out_data.mixed_sample, want.mixed_sample);
                if (out_data.voice_taken !== want.voice_taken)
                    report_mismatch("voice_taken", out_data.voice_taken, want.voice_taken);
                if (out_data.no_free_voice !== want.no_free_voice)
                    report_mismatch("no_free_voice", out_data.no_free_voice,
                                    want.no_free_voice);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (ready_mode == READY_ALWAYS)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= ready_pattern[0];
            if (pattern_age == 31)
            begin
                ready_pattern <= (ready_mode == READY_HEAVY) ? 16'($urandom) :
                                 16'($urandom | $urandom);
                pattern_age <= 0;
            end
            else
            begin
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
                pattern_age <= pattern_age + 1;
            end
        end
    end

    function automatic in_item_t random_item(logic [2:0] op);
        in_item_t    it;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        it = noise[$bits(in_item_t)-1:0];
        it.operation = op;
        return it;
    endfunction

    function automatic in_item_t start_item(logic [2:0] op, logic [15:0] addr,
                                            logic [16:0] len, logic [16:0] offset);
        in_item_t it;
        it = random_item(op);
        it.address     = addr;
        it.length      = len;
        it.loop_offset = offset;
        return it;
    endfunction

    function automatic in_item_t write_item(logic [15:0] addr, logic [7:0] value);
        in_item_t it;
        it = random_item(OP_WRITE);
        it.address     = addr;
        it.sample_byte = value;
        return it;
    endfunction

    function automatic in_item_t gain_item(logic [2:0] voice, logic [15:0] gain);
        in_item_t it;
        it = random_item(OP_SET_VOLUME);
        it.voice      = voice;
        it.voice_gain = gain;
        return it;
    endfunction

    function automatic logic [15:0] sound_address();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return 16'($urandom_range(511));
        else if (pick < 8)
            return 16'hFF00 + 16'($urandom_range(255));
        else
            return 16'($urandom);
    endfunction

    function automatic logic [16:0] sound_length();
        int pick;
        pick = $urandom_range(19);
        if (pick < 2)
            return '0;
        else if (pick < 12)
            return 17'($urandom_range(48, 1));
        else if (pick < 17)
            return 17'($urandom_range(600, 49));
        else if (pick == 17)
            return MAX_LENGTH;
        else if (pick == 18)
            return 17'($urandom_range(131071, 65537));
        else
            return 17'($urandom);
    endfunction

    function automatic in_item_t shaped_item();
        in_item_t    it;
        int          pick;
        int unsigned span;
        pick = $urandom_range(99);
        if (pick < 36)
            it = random_item(OP_TICK);
        else if (pick < 50)
        begin
            it = random_item(OP_WRITE);
            it.address = sound_address();
        end
        else if (pick < 70)
        begin
            it = random_item((pick < 60) ? OP_START_ONCE : OP_START_LOOP);
            it.address = sound_address();
            it.length  = sound_length();
            span = 32'((it.length > MAX_LENGTH) ? MAX_LENGTH : it.length);
            if (span != 0 && $urandom_range(3) != 0)
                it.loop_offset = 17'($urandom_range(span - 1));
        end
        else if (pick < 80)
            it = random_item(OP_STOP);
        else if (pick < 93)
        begin
            it = random_item(OP_SET_VOLUME);
            case ($urandom_range(4))
                0: it.voice_gain = '0;
                1: it.voice_gain = 16'hFFFF;
                2: it.voice_gain = UNITY_GAIN;
                3: it.voice_gain = 16'($urandom_range(512));
                default: ;
            endcase
        end
        else
            it = random_item($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7);
        return it;
    endfunction

    task automatic issue_item(in_item_t it);
        bit taken;
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        pending_results.push_back(mixer_predict(it));
        if (gaps_on)
        begin
            if (burst_left > 1)
                burst_left--;
            else
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(12, 1)) @(posedge clk);
                burst_left = $urandom_range(20, 1);
            end
        end
    endtask

    // a voice about to read a never-written byte gets it written or is stopped first
    task automatic send_item(in_item_t it);
        in_item_t fix;
        int       v;
        if (it.operation == OP_TICK)
        begin
            for (v = 0; v < NUM_VOICES; v++)
            begin
                if (voice_on[v] && !sample_known[voice_pos[v] % MEM_SPAN])
                begin
                    fix = random_item($urandom_range(1) ? OP_WRITE : OP_STOP);
                    fix.address = voice_pos[v][15:0];
                    fix.voice   = v[2:0];
                    issue_item(fix);
                end
            end
        end
        issue_item(it);
    endtask

    task automatic send_tick(logic [7:0] stream);
        in_item_t it;
        it = random_item(OP_TICK);
        it.stream_sample = stream;
        send_item(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_stream_gain(logic [15:0] gain);
        bit taken;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= gain;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        stream_gain = gain;
    endtask

    task automatic test_idle_outputs();
        send_tick(8'hFF);
        send_item(random_item(OP_SPARE_6));
        send_item(random_item(OP_SPARE_7));
    endtask

    task automatic test_stream_gain();
        set_stream_gain(16'hFFFF);
        send_tick(8'h00);
        send_tick(8'hFF);
        set_stream_gain(16'h0001);
        send_tick(8'h00);
        set_stream_gain(16'h0000);
    endtask

    task automatic test_voice_allocation();
        in_item_t it;
        send_item(write_item(16'h0000, 8'hFF));
        send_item(write_item(16'h0001, 8'h00));
        send_item(write_item(16'hFFFF, 8'h80));
        // oversized length, wraps past the top of memory
        send_item(start_item(OP_START_ONCE, 16'hFFFF, 17'h1FFFF, 17'h0));
        send_item(start_item(OP_START_LOOP, 16'h0000, 17'd2, 17'd1));
        // zero length plays a single byte
        send_item(start_item(OP_START_ONCE, 16'h0000, 17'd0, 17'd0));
        // loop point at or past the end means no loop
        send_item(start_item(OP_START_LOOP, 16'h0001, 17'd1, 17'd1));
        send_item(start_item(OP_START_LOOP, 16'h0000, 17'd3, 17'h1FFFF));
        repeat (3) send_item(start_item(OP_START_LOOP, 16'hFFFF, 17'd3, 17'd0));
        // every voice busy
        send_item(start_item(OP_START_ONCE, 16'h0000, 17'd1, 17'd0));
        send_item(gain_item(3'd7, 16'hFFFF));
        send_item(gain_item(3'd0, 16'h0000));
        send_tick(8'h80);
        it = random_item(OP_STOP);
        it.voice = 3'd1;
        send_item(it);
        send_item(start_item(OP_START_ONCE, 16'h0000, MAX_LENGTH, 17'd0));
        // gain stored on a voice that already ran out
        send_item(gain_item(3'd2, 16'h1234));
        send_tick(8'h00);
    endtask

    task automatic test_random_mix(int count, logic [15:0] gain, bit with_gaps,
                                   ready_mode_t mode);
        set_stream_gain(gain);
        gaps_on    = with_gaps;
        burst_left = $urandom_range(20, 1);
        ready_mode = mode;
        repeat (count) send_item(shaped_item());
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        gaps_on    = 1'b0;
        ready_mode = READY_ALWAYS;
        hold_requests <= hold_requests + 1;
        repeat (40) send_item(shaped_item());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_idle_outputs();
        test_stream_gain();
        test_voice_allocation();
        test_random_mix(300, 16'h0000, 1'b1, READY_LIGHT);
        test_random_mix(250, 16'hFFFF, 1'b0, READY_ALWAYS);
        test_random_mix(300, 16'($urandom), 1'b1, READY_HEAVY);
        test_backpressure();
        test_random_mix(300, 16'h0100, 1'b1, READY_LIGHT);
        test_random_mix(300, 16'($urandom_range(255)), 1'b0, READY_HEAVY);
        wait_idle();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== multi_voice_pcm_mixer.f =====
sv/mvpm_pkg.sv
sv/mvpm_ctrl.sv
sv/mvpm_datapath.sv
sv/multi_voice_pcm_mixer.sv
bench/multi_voice_pcm_mixer_tb.sv
